[hw/rtl/modbus_tcp_read_holding_responder_assert.svh]
// Assertion macros shared by the responder's checker.
// Needs nothing but a clock and a reset signal in scope at the point of use.
`ifndef MODBUS_TCP_READ_HOLDING_RESPONDER_ASSERT_SVH
`define MODBUS_TCP_READ_HOLDING_RESPONDER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define MTR_ASSERT_NOW(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("responder check failed");

// Next-cycle implication, disabled while reset is high.
`define MTR_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("responder check failed");

`endif

[hw/rtl/mtr_pkg.sv]
// Shared constants and types for the Modbus TCP read-holding responder.
// Used by every module of the block; depends on nothing.
package mtr_pkg;

  localparam int TABLE_DEPTH  = 128;
  localparam int MAX_QUANTITY = 123;

  // Table address and sweep counter widths follow from the depth.
  localparam int TBL_AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int TBL_CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [7:0] FUNC_READ_HOLDING = 8'h03;
  localparam logic [3:0] REQ_BYTES         = 4'd12;
  localparam logic [7:0] MBAP_BASE         = 8'd3;

  // Byte offsets inside the request header.
  localparam logic [3:0] POS_TID_HI  = 4'd0;
  localparam logic [3:0] POS_TID_LO  = 4'd1;
  localparam logic [3:0] POS_UNIT    = 4'd6;
  localparam logic [3:0] POS_FUNC    = 4'd7;
  localparam logic [3:0] POS_ADDR_HI = 4'd8;
  localparam logic [3:0] POS_ADDR_LO = 4'd9;
  localparam logic [3:0] POS_QTY_HI  = 4'd10;
  localparam logic [3:0] POS_QTY_LO  = 4'd11;

  // Result kinds carried on tuser.
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  localparam int OUT_TDATA_W = 88;

  typedef struct packed {
    logic        go;
    logic [15:0] trans_id;
    logic [7:0]  unit_id;
    logic [7:0]  func_code;
    logic [15:0] start_addr;
    logic [15:0] quantity;
  } req_t;

endpackage

[hw/rtl/mtr_table_store.sv]
// Register table memory with two registered read ports and its fill sweep.
// Depends on mtr_pkg for the depth and address widths.
module mtr_table_store
  import mtr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [TBL_AW-1:0] rd_addr_a,
  input  logic [TBL_AW-1:0] rd_addr_b,
  output logic [15:0]       rd_data_a,
  output logic [15:0]       rd_data_b,
  output logic              init_done
);

  logic [15:0]       mem [TABLE_DEPTH];
  logic [TBL_CW-1:0] fill_cnt;

  assign init_done = (fill_cnt == TBL_CW'(TABLE_DEPTH));

  // Sweep after reset: entry i gets i + 1.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_cnt <= '0;
    end else if (!init_done) begin
      fill_cnt <= fill_cnt + TBL_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!init_done) begin
      mem[fill_cnt[TBL_AW-1:0]] <= 16'(fill_cnt) + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

[hw/rtl/mtr_parser.sv]
// Request header capture: tracks the byte position and holds the request fields.
// Depends on mtr_pkg for offsets and the request struct.
module mtr_parser
  import mtr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_acc,
  input  logic [7:0] rx_byte,
  input  logic       frame_end,
  output req_t       req
);

  logic [3:0] byte_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos       <= '0;
      req.go         <= 1'b0;
      req.trans_id   <= '0;
      req.unit_id    <= '0;
      req.func_code  <= '0;
      req.start_addr <= '0;
      req.quantity   <= '0;
    end else begin
      // Full header seen once this byte brings the count to twelve.
      req.go <= byte_acc && frame_end && (byte_pos >= REQ_BYTES - 4'd1);
      if (byte_acc) begin
        unique case (byte_pos)
          POS_TID_HI:  req.trans_id[15:8]   <= rx_byte;
          POS_TID_LO:  req.trans_id[7:0]    <= rx_byte;
          POS_UNIT:    req.unit_id          <= rx_byte;
          POS_FUNC:    req.func_code        <= rx_byte;
          POS_ADDR_HI: req.start_addr[15:8] <= rx_byte;
          POS_ADDR_LO: req.start_addr[7:0]  <= rx_byte;
          POS_QTY_HI:  req.quantity[15:8]   <= rx_byte;
          POS_QTY_LO:  req.quantity[7:0]    <= rx_byte;
          default: ;
        endcase
        if (frame_end) begin
          byte_pos <= '0;
        end else if (byte_pos < REQ_BYTES) begin
          byte_pos <= byte_pos + 4'd1;
        end
      end
    end
  end

endmodule

[hw/rtl/mtr_sequencer.sv]
// Response sequencer: checks the request, walks the table and drives the result register.
// Depends on mtr_pkg; reads the table through mtr_table_store's ports.
module mtr_sequencer
  import mtr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  req_t                   req,
  output logic [TBL_AW-1:0]      rd_addr_a,
  output logic [TBL_AW-1:0]      rd_addr_b,
  input  logic [15:0]            rd_data_a,
  input  logic [15:0]            rd_data_b,
  output logic                   busy,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // trans_id, unit_id, func_code, data_bytes, mbap_length, first_word,
  // second_word, words_valid, zero pad (lowest bit first)
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast,
  // out_kind
  output logic [1:0]             m_axis_tuser
);

  typedef enum logic [1:0] {S_IDLE, S_OUT, S_LOAD} state_t;

  state_t      state;
  logic [7:0]  idx;
  logic [7:0]  remaining;
  logic [7:0]  dbytes;
  logic [7:0]  mlen;
  logic        bad_range;
  logic [16:0] end_addr;

  assign end_addr  = {1'b0, req.start_addr} + {1'b0, req.quantity};
  assign bad_range = (req.quantity > 16'(MAX_QUANTITY)) || (end_addr > 17'(TABLE_DEPTH));
  assign dbytes    = {req.quantity[6:0], 1'b0};
  assign mlen      = dbytes + MBAP_BASE;
  assign remaining = req.quantity[7:0] - idx;
  assign rd_addr_a = TBL_AW'(req.start_addr) + TBL_AW'(idx);
  assign rd_addr_b = rd_addr_a + TBL_AW'(1);
  assign busy      = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      idx           <= '0;
      m_axis_tvalid <= 1'b0;
      m_axis_tlast  <= 1'b0;
      m_axis_tuser  <= KIND_HEADER;
    end else begin
      unique case (state)
        S_IDLE: begin
          idx <= '0;
          if (req.go && req.func_code == FUNC_READ_HOLDING) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tlast  <= bad_range || (req.quantity == 16'd0);
            m_axis_tuser  <= bad_range ? KIND_REJECT : KIND_HEADER;
            m_axis_tdata  <= {6'd0, 2'd0, 16'd0, 16'd0,
                              bad_range ? MBAP_BASE : mlen,
                              bad_range ? 8'd0 : dbytes,
                              req.func_code, req.unit_id, req.trans_id};
            state         <= S_OUT;
          end
        end
        S_OUT: begin
          // Table words for the current index are read during this cycle.
          if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            state         <= m_axis_tlast ? S_IDLE : S_LOAD;
          end
        end
        S_LOAD: begin
          m_axis_tvalid <= 1'b1;
          m_axis_tlast  <= (remaining <= 8'd2);
          m_axis_tuser  <= KIND_DATA;
          m_axis_tdata  <= {6'd0,
                            (remaining >= 8'd2) ? 2'd2 : 2'd1,
                            (remaining >= 8'd2) ? rd_data_b : 16'd0,
                            rd_data_a, mlen, dbytes,
                            req.func_code, req.unit_id, req.trans_id};
          idx           <= idx + 8'd2;
          state         <= S_OUT;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/modbus_tcp_read_holding_responder.sv]
// Modbus TCP read-holding-registers responder, top level.
// Request bytes are taken one per cycle while s_axis_tready is high; after the last byte's
// transaction the header result passes the parser's req.go register and then the
// sequencer's output register, and each data result is built in S_LOAD once the previous
// one is taken. The input stalls for the whole response.
// Reset (rst, synchronous): clears control, then a fill pass writes all TABLE_DEPTH
// (128) table entries in turn; no input is taken until it ends.
module modbus_tcp_read_holding_responder
  import mtr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,   // rx_byte
  input  logic                   s_axis_tlast,   // frame_end
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // trans_id, unit_id, func_code, data_bytes, mbap_length, first_word,
  // second_word, words_valid, zero pad (lowest bit first)
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast,   // last_of_run
  output logic [1:0]             m_axis_tuser    // out_kind
);

  req_t              req;
  logic              init_done;
  logic              busy;
  logic [TBL_AW-1:0] rd_addr_a;
  logic [TBL_AW-1:0] rd_addr_b;
  logic [15:0]       rd_data_a;
  logic [15:0]       rd_data_b;
  logic              byte_acc;

  // Hold input while the table fills, a request is pending or a response runs.
  assign s_axis_tready = init_done && !busy && !req.go;
  assign byte_acc      = s_axis_tvalid && s_axis_tready;

  mtr_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .byte_acc  (byte_acc),
    .rx_byte   (s_axis_tdata),
    .frame_end (s_axis_tlast),
    .req       (req)
  );

  mtr_table_store u_table (
    .clk       (clk),
    .rst       (rst),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b),
    .init_done (init_done)
  );

  mtr_sequencer u_seq (
    .clk           (clk),
    .rst           (rst),
    .req           (req),
    .rd_addr_a     (rd_addr_a),
    .rd_addr_b     (rd_addr_b),
    .rd_data_a     (rd_data_a),
    .rd_data_b     (rd_data_b),
    .busy          (busy),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

[hw/rtl/mtr_checker.sv]
// Port-level checks for the responder, bound onto the top level.
// Depends on mtr_pkg and the assertion macros header.
`include "modbus_tcp_read_holding_responder_assert.svh"

module mtr_checker
  import mtr_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tlast,
  input logic [1:0]             m_axis_tuser
);

  logic                   out_wait;
  logic [OUT_TDATA_W+2:0] out_bus;
  logic                   out_reject;
  logic                   out_data;
  logic [7:0]             out_dbytes;
  logic [7:0]             out_mlen;
  logic [1:0]             out_nwords;

  assign out_wait   = m_axis_tvalid && !m_axis_tready;
  assign out_bus    = {m_axis_tlast, m_axis_tuser, m_axis_tdata};
  assign out_reject = m_axis_tvalid && (m_axis_tuser == KIND_REJECT);
  assign out_data   = m_axis_tvalid && (m_axis_tuser == KIND_DATA);
  assign out_dbytes = m_axis_tdata[39:32];
  assign out_mlen   = m_axis_tdata[47:40];
  assign out_nwords = m_axis_tdata[81:80];

  // A stalled result keeps its payload.
  `MTR_ASSERT_NEXT(a_out_hold, clk, rst, out_wait, m_axis_tvalid && $stable(out_bus))

  // No request byte is taken while a result waits.
  `MTR_ASSERT_NOW(a_no_overlap, clk, rst, m_axis_tvalid, !s_axis_tready)

  // A rejected request is a one-result response.
  `MTR_ASSERT_NOW(a_reject_last, clk, rst, out_reject, m_axis_tlast)

  // MBAP length always exceeds the byte count by three.
  `MTR_ASSERT_NOW(a_mbap_len, clk, rst, m_axis_tvalid, out_mlen == out_dbytes + MBAP_BASE)

  // A data result carries at least one word.
  `MTR_ASSERT_NOW(a_data_words, clk, rst, out_data, out_nwords == 2'd1 || out_nwords == 2'd2)

endmodule

bind modbus_tcp_read_holding_responder mtr_checker u_mtr_checker (.*);
